// ===== hw/rtl/cspfr_pkg.sv =====
// Shared types, constants and routing function for the setpoint frame receiver.
package cspfr_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int PIDX_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [7:0] START_BYTE = 8'h24;

  // Item kinds carried on in_tuser.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REMOTE_LOCK = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WELD_MODE   = 1'd1;

  // Weld modes.
  localparam logic [2:0] MODE_CC   = 3'd0;
  localparam logic [2:0] MODE_MIG  = 3'd1;
  localparam logic [2:0] MODE_FCAW = 3'd2;
  localparam logic [2:0] MODE_TIG  = 3'd3;
  localparam logic [2:0] MODE_NONE = 3'd4;

  // Destinations.
  localparam logic [1:0] DEST_NONE    = 2'd0;
  localparam logic [1:0] DEST_CURRENT = 2'd1;
  localparam logic [1:0] DEST_MIG     = 2'd2;
  localparam logic [1:0] DEST_FCAW    = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [1:0]  destination;
    logic [15:0] voltage_setpoint;
    logic [15:0] speed_setpoint;
  } result_t;

  function automatic logic [1:0] route(input logic [2:0] mode);
    logic [1:0] dest;
    case (mode)
      MODE_CC:   dest = DEST_CURRENT;
      MODE_MIG:  dest = DEST_MIG;
      MODE_FCAW: dest = DEST_FCAW;
      MODE_TIG:  dest = DEST_CURRENT;
      default:   dest = DEST_NONE;
    endcase
    return dest;
  endfunction

endpackage

// ===== hw/rtl/cspfr_in_stage.sv =====
// Input register stage: captures one item per transfer and holds it until processed.
module cspfr_in_stage
  import cspfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/cspfr_frame_core.sv =====
// Frame state, payload storage, checksum compare and setpoint formation.
module cspfr_frame_core
  import cspfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  item_t      item,
  input  logic       advance,
  input  logic       remote_lock,
  input  logic [2:0] weld_mode,
  output logic       has_result,
  output result_t    result
);

  logic             in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             pending_r, pending_nxt;
  logic [7:0]       payload_r [PAYLOAD_BYTES];
  logic [7:0]       data_b [4];
  logic             at_checksum;
  logic             sum_match;
  logic             store_byte;

  assign at_checksum = in_frame_r && (idx_r == IDX_W'(PAYLOAD_BYTES));
  assign sum_match   = (sum_r == item.rx_byte);
  assign has_result  = item_valid && (item.op == OP_BYTE) && at_checksum;
  assign store_byte  = advance && (item.op == OP_BYTE) && in_frame_r && !at_checksum;

  // Data bytes beyond the payload length read as zero.
  for (genvar i = 0; i < 4; i++) begin : g_data
    if (i < PAYLOAD_BYTES) begin : g_have
      assign data_b[i] = payload_r[i];
    end else begin : g_zero
      assign data_b[i] = 8'd0;
    end
  end

  always_comb begin
    result.checksum_ok      = sum_match;
    result.destination      = DEST_NONE;
    result.voltage_setpoint = 16'd0;
    result.speed_setpoint   = 16'd0;
    if (sum_match) begin
      result.destination      = route(weld_mode);
      result.voltage_setpoint = {data_b[1], data_b[0]};
      result.speed_setpoint   = {data_b[3], data_b[2]};
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    pending_nxt  = pending_r;
    if (advance) begin
      if (item.op == OP_CLEAR) begin
        pending_nxt = 1'b0;
      end else if (!in_frame_r) begin
        if ((item.rx_byte == START_BYTE) && !pending_r && !remote_lock) begin
          in_frame_nxt = 1'b1;
          idx_nxt      = '0;
          sum_nxt      = 8'd0;
        end
      end else if (!at_checksum) begin
        sum_nxt = sum_r + item.rx_byte;
        idx_nxt = idx_r + 1'b1;
      end else begin
        in_frame_nxt = 1'b0;
        idx_nxt      = '0;
        if (sum_match) begin
          pending_nxt = 1'b1;
        end else begin
          sum_nxt = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r      <= '0;
      sum_r      <= 8'd0;
      pending_r  <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      pending_r  <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      payload_r[idx_r[PIDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule

// ===== hw/rtl/checksummed_setpoint_frame_receiver.sv =====
// A result is offered on out_tvalid the cycle after its checksum byte leaves the input register.
// Throughput: one item per cycle while the output side does not stall; input register, one logic pass, output register.
// The input side keeps taking items while a result waits, unless that wait would block
// the next result. Items that produce no result never wait on the output side.
// Reset (rst_n low, synchronous) idles the frame parser, clears the pending flag and
// both stage valids, and loads remote_lock 0 and weld_mode 4.
module checksummed_setpoint_frame_receiver
  import cspfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [15:0] voltage_setpoint, [31:16] speed_setpoint
  output logic [2:0]            out_tuser,  // [0] checksum_ok, [2:1] destination
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [2:0]            cfg_wdata
);

  item_t      in_item;
  item_t      item;
  logic       item_valid;
  logic       has_result;
  result_t    result;
  logic       advance;
  logic       out_free;
  logic       remote_lock_r;
  logic [2:0] weld_mode_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  assign in_item.op      = in_tuser;
  assign in_item.rx_byte = in_tdata;

  assign out_free = !out_valid_r || out_tready;
  assign advance  = item_valid && (!has_result || out_free);

  cspfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cspfr_frame_core u_frame_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .advance     (advance),
    .remote_lock (remote_lock_r),
    .weld_mode   (weld_mode_r),
    .has_result  (has_result),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_lock_r <= 1'b0;
      weld_mode_r   <= MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_REMOTE_LOCK: remote_lock_r <= cfg_wdata[0];
        CFG_WELD_MODE:   weld_mode_r   <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.speed_setpoint, out_res_r.voltage_setpoint};
  assign out_tuser  = {out_res_r.destination, out_res_r.checksum_ok};

endmodule
